// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPH_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sph_pkg.sv =====
package sph_pkg;

    // Table geometry.
    localparam int unsigned TABLE_SLOTS = 256;
    localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int unsigned CNT_W       = SLOT_W + 1;

    // Field widths.
    localparam int unsigned SIZE_W     = 9;
    localparam int unsigned STRIDE_W   = 8;
    localparam int unsigned HASH_W     = 8;
    localparam int unsigned ID_W       = 31;
    localparam int unsigned OUT_SLOT_W = 8;
    localparam int unsigned PASSED_W   = 8;
    localparam int unsigned TOTAL_W    = 63;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;

    // The remainder loop walks one bit of the hash or stride per cycle.
    localparam int unsigned DIV_W     = HASH_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

    // Reset values of the configuration registers.
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(256);
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_STRIDE = CFG_IDX_W'(1);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_ABSENT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH_MOD,
        ST_STEP_MOD,
        ST_PROBE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t                command;
        logic [ID_W-1:0]     object_id;
        logic [HASH_W-1:0]   hash_value;
    } item_t;

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] slot_index;
        logic [PASSED_W-1:0]   passed_slots;
        logic [TOTAL_W-1:0]    total_passed;
        status_t               status;
    } res_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

endpackage

// ===== design/sph_if.sv =====
// Input item channel.
interface sph_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [sph_pkg::ID_W-1:0]    object_id;
    logic [sph_pkg::HASH_W-1:0]  hash_value;

    modport source (output valid, command, object_id, hash_value, input ready);
    modport sink (input valid, command, object_id, hash_value, output ready);
endinterface

// Result item channel.
interface sph_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [sph_pkg::OUT_SLOT_W-1:0] slot_index;
    logic [sph_pkg::PASSED_W-1:0]   passed_slots;
    logic [sph_pkg::TOTAL_W-1:0]    total_passed;
    logic [sph_pkg::STATUS_W-1:0]   status;

    modport source (output valid, slot_index, passed_slots, total_passed, status,
                    input ready);
    modport sink (input valid, slot_index, passed_slots, total_passed, status,
                  output ready);
endinterface

// Configuration write channel.
interface sph_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sph_pkg::CFG_IDX_W-1:0]    index;
    logic [sph_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/stride_probe_hash_table_core.sv =====
// Insert: the hash and then the stride are reduced bit by bit, then slots are probed in
// turn (1 to the effective table size) and the result is handed over. Removal: owner
// ids are read slot by slot from slot 0 until a match or the last slot of the store.
// One item at a time; the next item can be taken from the cycle after the result is
// handed to the output register. Reset clears occupancy flags and the total at once
// and restores size and stride.
module stride_probe_hash_table_core
(
    input  logic         clk,
    input  logic         rst_n,
    sph_req_if.sink      req,
    sph_rsp_if.source    rsp,
    sph_cfg_if.sink      cfg
);

    logic [sph_pkg::SIZE_W-1:0]   table_size_reg;
    logic [sph_pkg::STRIDE_W-1:0] probe_stride_reg;
    logic [sph_pkg::CNT_W-1:0]    size_eff;
    logic                         start;
    logic                         res_take;
    logic                         out_vld_reg;
    sph_pkg::res_t                out_res_reg;
    sph_pkg::res_t                res;
    sph_pkg::seq_status_t         stat;
    sph_pkg::item_t               item;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg   <= sph_pkg::SIZE_RESET;
            probe_stride_reg <= sph_pkg::STRIDE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sph_pkg::REG_TABLE_SIZE:
                begin
                    table_size_reg <= cfg.data[sph_pkg::SIZE_W-1:0];
                end
                sph_pkg::REG_PROBE_STRIDE:
                begin
                    probe_stride_reg <= cfg.data[sph_pkg::STRIDE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Effective size: zero acts as one, oversize clamps to the slot count.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size_eff = sph_pkg::CNT_W'(1);
        end
        else if (32'(table_size_reg) > sph_pkg::TABLE_SLOTS)
        begin
            size_eff = sph_pkg::CNT_W'(sph_pkg::TABLE_SLOTS);
        end
        else
        begin
            size_eff = sph_pkg::CNT_W'(table_size_reg);
        end
    end

    // Input handshake.
    assign req.ready       = stat.idle;
    assign start           = req.valid && stat.idle;
    assign item.command    = sph_pkg::cmd_t'(req.command);
    assign item.object_id  = req.object_id;
    assign item.hash_value = req.hash_value;

    sph_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .size_eff (size_eff),
        .stride   (probe_stride_reg),
        .res_take (res_take),
        .stat     (stat),
        .res      (res)
    );

    // Output register decouples the sequencer from the result consumer.
    assign res_take = stat.done && (!out_vld_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.slot_index   = out_res_reg.slot_index;
    assign rsp.passed_slots = out_res_reg.passed_slots;
    assign rsp.total_passed = out_res_reg.total_passed;
    assign rsp.status       = out_res_reg.status;

endmodule

// ===== design/sph_mod_unit.sv =====
// Shared add and reduce unit: returns (a + b + cin) mod m for a, b below m.
// It serves the bitwise remainder steps and every probe advance.
module sph_mod_unit
(
    input  logic [sph_pkg::SLOT_W-1:0] a,
    input  logic [sph_pkg::SLOT_W-1:0] b,
    input  logic                       cin,
    input  logic [sph_pkg::CNT_W-1:0]  m,
    output logic [sph_pkg::SLOT_W-1:0] r
);

    logic [sph_pkg::CNT_W:0] sum;
    logic [sph_pkg::CNT_W:0] diff;

    // One add, then one conditional subtract since the sum stays below 2m.
    always_comb
    begin
        sum  = {2'b00, a} + {2'b00, b} + {{sph_pkg::CNT_W{1'b0}}, cin};
        diff = sum - {1'b0, m};
        if (sum >= {1'b0, m})
        begin
            r = diff[sph_pkg::SLOT_W-1:0];
        end
        else
        begin
            r = sum[sph_pkg::SLOT_W-1:0];
        end
    end

endmodule

// ===== design/sph_owner_ram.sv =====
// Owner id store: one write port, one registered read port.
module sph_owner_ram
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [sph_pkg::SLOT_W-1:0] waddr,
    input  logic [sph_pkg::ID_W-1:0]   wdata,
    input  logic [sph_pkg::SLOT_W-1:0] raddr,
    output logic [sph_pkg::ID_W-1:0]   rdata
);

    logic [sph_pkg::ID_W-1:0] mem [sph_pkg::TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sph_seq.sv =====
// Sequencer: reduces hash and stride, probes one slot per cycle on insert,
// and scans the owner store one slot per cycle on removal.
module sph_seq
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  sph_pkg::item_t               item,
    input  logic [sph_pkg::CNT_W-1:0]    size_eff,
    input  logic [sph_pkg::STRIDE_W-1:0] stride,
    input  logic                         res_take,
    output sph_pkg::seq_status_t         stat,
    output sph_pkg::res_t                res
);

    localparam int unsigned SLOT_W = sph_pkg::SLOT_W;
    localparam int unsigned CNT_W  = sph_pkg::CNT_W;

    sph_pkg::state_t                   state_reg, state_next;
    logic [sph_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SLOT_W-1:0]                 pos_reg, pos_next;
    logic [SLOT_W-1:0]                 step_reg, step_next;
    logic [CNT_W-1:0]                  k_reg, k_next;
    logic [CNT_W-1:0]                  idx_reg, idx_next;
    logic                              lag_vld_reg, lag_vld_next;
    logic [SLOT_W-1:0]                 lag_idx_reg, lag_idx_next;
    logic [sph_pkg::TABLE_SLOTS-1:0]   occ_reg, occ_next;
    logic [sph_pkg::TOTAL_W-1:0]       total_reg, total_next;
    sph_pkg::res_t                     res_reg, res_next;
    logic [sph_pkg::ID_W-1:0]          id_reg;
    logic [sph_pkg::HASH_W-1:0]        hash_reg;

    logic [SLOT_W-1:0]                 unit_a;
    logic [SLOT_W-1:0]                 unit_b;
    logic                              unit_cin;
    logic [SLOT_W-1:0]                 unit_r;

    logic                              ram_we;
    logic [sph_pkg::ID_W-1:0]          ram_rdata;

    logic [sph_pkg::TOTAL_W:0]         total_sum;
    logic [sph_pkg::TOTAL_W-1:0]       total_sat;
    logic [CNT_W-1:0]                  k_inc;
    logic                              hit;

    sph_mod_unit u_mod
    (
        .a   (unit_a),
        .b   (unit_b),
        .cin (unit_cin),
        .m   (size_eff),
        .r   (unit_r)
    );

    sph_owner_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (id_reg),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // Operand selection for the shared unit.
    always_comb
    begin
        case (state_reg)
            sph_pkg::ST_STEP_MOD:
            begin
                unit_a   = step_reg;
                unit_b   = step_reg;
                unit_cin = stride[cnt_reg];
            end
            sph_pkg::ST_PROBE:
            begin
                unit_a   = pos_reg;
                unit_b   = step_reg;
                unit_cin = 1'b0;
            end
            default:
            begin
                unit_a   = pos_reg;
                unit_b   = pos_reg;
                unit_cin = hash_reg[cnt_reg];
            end
        endcase
    end

    // Saturating running total and the search match.
    always_comb
    begin
        total_sum = {1'b0, total_reg} + (sph_pkg::TOTAL_W + 1)'(k_reg);
        total_sat = total_sum[sph_pkg::TOTAL_W] ? sph_pkg::TOTAL_MAX
                                                : total_sum[sph_pkg::TOTAL_W-1:0];
        k_inc     = k_reg + CNT_W'(1);
        hit       = lag_vld_reg && occ_reg[lag_idx_reg] && (ram_rdata == id_reg);
    end

    // Next state and datapath.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        step_next    = step_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        lag_vld_next = lag_vld_reg;
        lag_idx_next = lag_idx_reg;
        occ_next     = occ_reg;
        total_next   = total_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;

        case (state_reg)
            sph_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (item.command == sph_pkg::CMD_INSERT)
                    begin
                        pos_next   = '0;
                        step_next  = '0;
                        k_next     = '0;
                        cnt_next   = sph_pkg::DIV_CNT_W'(sph_pkg::DIV_W - 1);
                        state_next = sph_pkg::ST_HASH_MOD;
                    end
                    else
                    begin
                        idx_next     = '0;
                        lag_vld_next = 1'b0;
                        state_next   = sph_pkg::ST_SEARCH;
                    end
                end
            end

            sph_pkg::ST_HASH_MOD:
            begin
                pos_next = unit_r;
                cnt_next = cnt_reg - sph_pkg::DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    cnt_next   = sph_pkg::DIV_CNT_W'(sph_pkg::DIV_W - 1);
                    state_next = sph_pkg::ST_STEP_MOD;
                end
            end

            sph_pkg::ST_STEP_MOD:
            begin
                step_next = unit_r;
                cnt_next  = cnt_reg - sph_pkg::DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = sph_pkg::ST_PROBE;
                end
            end

            sph_pkg::ST_PROBE:
            begin
                if (!occ_reg[pos_reg])
                begin
                    // Free slot: claim it and record the owner.
                    occ_next[pos_reg]     = 1'b1;
                    ram_we                = 1'b1;
                    total_next            = total_sat;
                    res_next.slot_index   = sph_pkg::OUT_SLOT_W'(pos_reg);
                    res_next.passed_slots = sph_pkg::PASSED_W'(k_reg);
                    res_next.total_passed = total_sat;
                    res_next.status       = sph_pkg::STATUS_OK;
                    state_next            = sph_pkg::ST_DONE;
                end
                else if (k_inc == size_eff)
                begin
                    // Whole probe cycle seen occupied.
                    res_next.slot_index   = '0;
                    res_next.passed_slots = '0;
                    res_next.total_passed = total_reg;
                    res_next.status       = sph_pkg::STATUS_FULL;
                    state_next            = sph_pkg::ST_DONE;
                end
                else
                begin
                    pos_next = unit_r;
                    k_next   = k_inc;
                end
            end

            sph_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    occ_next[lag_idx_reg] = 1'b0;
                    res_next.slot_index   = sph_pkg::OUT_SLOT_W'(lag_idx_reg);
                    res_next.passed_slots = '0;
                    res_next.total_passed = total_reg;
                    res_next.status       = sph_pkg::STATUS_OK;
                    state_next            = sph_pkg::ST_DONE;
                end
                else if (lag_vld_reg && (lag_idx_reg == SLOT_W'(sph_pkg::TABLE_SLOTS - 1)))
                begin
                    res_next.slot_index   = '0;
                    res_next.passed_slots = '0;
                    res_next.total_passed = total_reg;
                    res_next.status       = sph_pkg::STATUS_ABSENT;
                    state_next            = sph_pkg::ST_DONE;
                end
                else
                begin
                    // The read issued this cycle is compared in the next one.
                    lag_vld_next = !idx_reg[SLOT_W];
                    lag_idx_next = idx_reg[SLOT_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                end
            end

            sph_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = sph_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sph_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sph_pkg::ST_IDLE;
            lag_vld_reg <= 1'b0;
            occ_reg     <= '0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            lag_vld_reg <= lag_vld_next;
            occ_reg     <= occ_next;
            total_reg   <= total_next;
        end
    end

    // Working registers and the captured item.
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        pos_reg     <= pos_next;
        step_reg    <= step_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        lag_idx_reg <= lag_idx_next;
        res_reg     <= res_next;
        if (start)
        begin
            id_reg   <= item.object_id;
            hash_reg <= item.hash_value;
        end
    end

    assign stat.idle = (state_reg == sph_pkg::ST_IDLE);
    assign stat.done = (state_reg == sph_pkg::ST_DONE);
    assign res       = res_reg;

endmodule

// ===== design/sph_checker.sv =====
`include "assert_macros.svh"

// Port-level checks on the hash table core.
module sph_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  logic [sph_pkg::OUT_SLOT_W-1:0] slot_index,
    input  logic [sph_pkg::PASSED_W-1:0]   passed_slots,
    input  logic [sph_pkg::TOTAL_W-1:0]    total_passed,
    input  logic [sph_pkg::STATUS_W-1:0]   status
);

    logic [sph_pkg::TOTAL_W-1:0] last_total_reg;

    // Total seen with the most recent delivered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            last_total_reg <= total_passed;
        end
    end

    // A stalled result stays valid and keeps its slot index and total.
    `SPH_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(total_passed) && $stable(slot_index), "stalled result changed")

    // The core works on one item at a time.
    `SPH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready, "item taken while busy")

    // Error results carry no slot and no pass count.
    `SPH_ASSERT_IMPLY(a_error_zero, clk, rst_n, rsp_valid && (status != sph_pkg::STATUS_OK), (slot_index == '0) && (passed_slots == '0), "error result with nonzero fields")

    // The running total never decreases.
    `SPH_ASSERT_IMPLY(a_total_mono, clk, rst_n, rsp_valid && rsp_ready, total_passed >= last_total_reg, "running total decreased")

endmodule

bind stride_probe_hash_table_core sph_checker u_sph_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .slot_index   (rsp.slot_index),
    .passed_slots (rsp.passed_slots),
    .total_passed (rsp.total_passed),
    .status       (rsp.status)
);
